>>> src/pfa_pkg.sv
// Shared types and codes for the pool first-fit allocator.
// Used by every module of the block; depends on nothing.
`default_nettype none
package pfa_pkg;

  // Allocation granule in bytes; it must be a power of two.
  localparam int GRANULE = 64;

  localparam logic [2:0] ACT_CREATE = 3'd0;
  localparam logic [2:0] ACT_DELETE = 3'd1;
  localparam logic [2:0] ACT_ALLOC  = 3'd2;
  localparam logic [2:0] ACT_FREE   = 3'd3;
  localparam logic [2:0] ACT_QUERY  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NO_ROOM = 2'd2;
  localparam logic [1:0] ST_IN_USE  = 2'd3;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
    logic        is_free;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  new_pool;
    logic [31:0] block_address;
    logic [31:0] bytes_free;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_DEL_RD, S_DEL_EV, S_SUM_RD, S_SUM_EV, S_RND_WAIT,
    S_FIT_RD, S_FIT_EV, S_UP_RD, S_UP_WR, S_SPLIT1, S_SPLIT2, S_FREE_RD,
    S_FREE_EV, S_NX_RD, S_NX_EV, S_PV_RD, S_PV_EV, S_MERGE, S_DN_RD,
    S_DN_WR, S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> src/pfa_table.sv
// Block table memory: one write port and one registered read port.
// Depends on pfa_pkg for the entry type.
`default_nettype none
module pfa_table #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire pfa_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output pfa_pkg::entry_t      rdata
);
  import pfa_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> src/pfa_rnd.sv
// Rounds a byte count up to a whole number of granules.
// Depends on pfa_pkg for the granule size, which is a power of two.
`default_nettype none
module pfa_rnd (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] size,
  output logic             done,
  output logic [32:0]      need
);
  import pfa_pkg::*;

  localparam logic [31:0] GMASK = 32'(GRANULE - 1);

  logic [31:0] size_r;
  logic        done_r;
  logic [31:0] rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else if (start) begin
      size_r <= size;
      done_r <= 1'b1;
    end
  end

  assign rem  = size_r & GMASK;
  assign done = done_r;
  assign need = 33'(size_r) + ((rem == 32'd0) ? 33'd0 : (33'(GRANULE) - 33'(rem)));

endmodule
`default_nettype wire

>>> src/pfa_ctrl.sv
// Request sequencer: pool registers, table walks, splits, merges and shifts.
// Depends on pfa_pkg; drives the pfa_table ports and the pfa_rnd unit.
`default_nettype none
module pfa_ctrl #(
  parameter int NUM_POOLS       = 8,
  parameter int BLOCKS_PER_POOL = 32,
  parameter int AW              = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2:0]       action,
  input  wire logic [2:0]       pool_id,
  input  wire logic [31:0]      req_size,
  input  wire logic [31:0]      address,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output pfa_pkg::result_t      res,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output pfa_pkg::entry_t       mem_wdata,
  output logic [AW-1:0]         mem_raddr,
  input  wire pfa_pkg::entry_t  mem_q,
  output logic                  rnd_start,
  input  wire logic             rnd_done,
  input  wire logic [32:0]      rnd_need
);
  import pfa_pkg::*;

  localparam int PW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int CW = $clog2(BLOCKS_PER_POOL + 1);

  state_t state_r, state_nxt;

  logic          pool_live_r [NUM_POOLS];
  logic [CW-1:0] block_count_r [NUM_POOLS];

  logic [2:0]    act_r;
  logic [2:0]    pid_r;
  logic [PW-1:0] pool_r;
  logic [31:0]   size_r;
  logic [31:0]   addr_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] j_r;
  logic [1:0]    sh_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   acc_r;
  logic [32:0]   need_r;
  logic          in_use_r;
  logic          nxt_free_r;
  logic          prv_free_r;
  entry_t        ent_r;
  entry_t        next_r;
  entry_t        prev_r;
  result_t       res_r;

  logic          pool_ok;
  logic          slot_found;
  logic [PW-1:0] slot_idx;
  logic [CW:0]   idx_w;
  logic [CW:0]   j_w;
  logic          scan_end;
  logic          fit_hit;
  logic          free_hit;
  logic          dn_end;
  logic [32:0]   sat_sum;
  logic [31:0]   merge_len;

  function automatic logic [AW-1:0] ea(input logic [PW-1:0] p, input logic [CW:0] i);
    ea = AW'(32'(p) * BLOCKS_PER_POOL + 32'(i));
  endfunction

  assign pool_ok  = (32'(pid_r) < NUM_POOLS) && pool_live_r[PW'(pid_r)];
  assign idx_w    = {1'b0, idx_r};
  assign j_w      = {1'b0, j_r};
  assign scan_end = (idx_r == cnt_r);
  assign fit_hit  = mem_q.is_free && (33'(mem_q.length) >= need_r);
  assign free_hit = (mem_q.start == addr_r) && !mem_q.is_free;
  assign dn_end   = ((j_w + (CW+1)'(sh_r)) >= {1'b0, cnt_r});
  assign sat_sum  = 33'(acc_r) + 33'(mem_q.length);
  assign merge_len = nxt_free_r ? (ent_r.length + next_r.length) : ent_r.length;

  always_comb begin
    slot_found = 1'b0;
    slot_idx   = '0;
    for (int i = 0; i < NUM_POOLS; i++) begin
      if (!pool_live_r[i] && !slot_found) begin
        slot_found = 1'b1;
        slot_idx   = PW'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        if (pool_ok) begin
          if (act_r == ACT_DELETE) state_nxt = S_DEL_RD;
          if (act_r == ACT_QUERY) state_nxt = S_SUM_RD;
          if (act_r == ACT_ALLOC && size_r != 32'd0) state_nxt = S_SUM_RD;
          if (act_r == ACT_FREE && addr_r != 32'd0) state_nxt = S_FREE_RD;
        end
      end
      S_DEL_RD:  state_nxt = scan_end ? S_DONE : S_DEL_EV;
      S_DEL_EV:  state_nxt = S_DEL_RD;
      S_SUM_RD: begin
        if (!scan_end) state_nxt = S_SUM_EV;
        else if (act_r == ACT_QUERY) state_nxt = S_DONE;
        else state_nxt = S_RND_WAIT;
      end
      S_SUM_EV:  state_nxt = S_SUM_RD;
      S_RND_WAIT: begin
        if (rnd_done) state_nxt = (size_r <= acc_r) ? S_FIT_RD : S_DONE;
      end
      S_FIT_RD:  state_nxt = scan_end ? S_DONE : S_FIT_EV;
      S_FIT_EV: begin
        if (!fit_hit) state_nxt = S_FIT_RD;
        else if (33'(mem_q.length) == need_r) state_nxt = S_DONE;
        else if (cnt_r < CW'(BLOCKS_PER_POOL)) state_nxt = S_UP_RD;
        else state_nxt = S_DONE;
      end
      S_UP_RD:   state_nxt = (j_r == idx_r) ? S_SPLIT1 : S_UP_WR;
      S_UP_WR:   state_nxt = S_UP_RD;
      S_SPLIT1:  state_nxt = S_SPLIT2;
      S_SPLIT2:  state_nxt = S_DONE;
      S_FREE_RD: state_nxt = scan_end ? S_DONE : S_FREE_EV;
      S_FREE_EV: state_nxt = free_hit ? S_NX_RD : S_FREE_RD;
      S_NX_RD:   state_nxt = ((idx_w + 1'b1) < {1'b0, cnt_r}) ? S_NX_EV : S_PV_RD;
      S_NX_EV:   state_nxt = S_PV_RD;
      S_PV_RD:   state_nxt = (idx_r != '0) ? S_PV_EV : S_MERGE;
      S_PV_EV:   state_nxt = S_MERGE;
      S_MERGE:   state_nxt = (prv_free_r || nxt_free_r) ? S_DN_RD : S_DONE;
      S_DN_RD:   state_nxt = dn_end ? S_DONE : S_DN_WR;
      S_DN_WR:   state_nxt = S_DN_RD;
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    rnd_start = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = ea(pool_r, idx_w);
    mem_wdata = mem_q;
    mem_raddr = ea(pool_r, idx_w);
    unique case (state_r)
      S_IDLE:   in_ready = 1'b1;
      S_DECODE: begin
        rnd_start = (act_r == ACT_ALLOC);
        if (act_r == ACT_CREATE && addr_r != 32'd0 && size_r != 32'd0 && slot_found) begin
          mem_we    = 1'b1;
          mem_waddr = ea(slot_idx, '0);
          mem_wdata = '{start: addr_r, length: size_r, is_free: 1'b1};
        end
      end
      S_FIT_EV: begin
        if (fit_hit && 33'(mem_q.length) == need_r) begin
          mem_we    = 1'b1;
          mem_wdata = '{start: mem_q.start, length: mem_q.length, is_free: 1'b0};
        end
      end
      S_UP_RD:  mem_raddr = ea(pool_r, j_w - 1'b1);
      S_UP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ea(pool_r, j_w);
      end
      S_SPLIT1: begin
        mem_we    = 1'b1;
        mem_wdata = '{start: ent_r.start, length: need_r[31:0], is_free: 1'b0};
      end
      S_SPLIT2: begin
        mem_we    = 1'b1;
        mem_waddr = ea(pool_r, idx_w + 1'b1);
        mem_wdata = '{start: ent_r.start + need_r[31:0],
                      length: ent_r.length - need_r[31:0], is_free: 1'b1};
      end
      S_NX_RD:  mem_raddr = ea(pool_r, idx_w + 1'b1);
      S_PV_RD:  mem_raddr = ea(pool_r, idx_w - 1'b1);
      S_MERGE: begin
        mem_we = 1'b1;
        if (prv_free_r) begin
          mem_waddr = ea(pool_r, idx_w - 1'b1);
          mem_wdata = '{start: prev_r.start, length: prev_r.length + merge_len,
                        is_free: 1'b1};
        end else begin
          mem_wdata = '{start: ent_r.start, length: merge_len, is_free: 1'b1};
        end
      end
      S_DN_RD:  mem_raddr = ea(pool_r, j_w + (CW+1)'(sh_r));
      S_DN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ea(pool_r, j_w);
      end
      S_DONE:   res_valid = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < NUM_POOLS; i++) begin
        pool_live_r[i]   <= 1'b0;
        block_count_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            act_r  <= action;
            pid_r  <= pool_id;
            pool_r <= PW'(pool_id);
            size_r <= req_size;
            addr_r <= address;
          end
        end
        S_DECODE: begin
          idx_r    <= '0;
          acc_r    <= 32'd0;
          in_use_r <= 1'b0;
          cnt_r    <= block_count_r[pool_r];
          if (act_r == ACT_CREATE && addr_r != 32'd0 && size_r != 32'd0) begin
            if (slot_found) begin
              pool_live_r[slot_idx]   <= 1'b1;
              block_count_r[slot_idx] <= CW'(1);
              res_r <= '{status: ST_OK, new_pool: 3'(slot_idx), block_address: 32'd0,
                         bytes_free: 32'd0};
            end else begin
              res_r <= '{status: ST_NO_ROOM, new_pool: 3'd0, block_address: 32'd0,
                         bytes_free: 32'd0};
            end
          end else begin
            res_r <= '{status: ST_INVALID, new_pool: 3'd0, block_address: 32'd0,
                       bytes_free: 32'd0};
          end
        end
        S_DEL_RD: begin
          if (scan_end) begin
            if (in_use_r) begin
              res_r.status <= ST_IN_USE;
            end else begin
              res_r.status          <= ST_OK;
              pool_live_r[pool_r]   <= 1'b0;
              block_count_r[pool_r] <= '0;
            end
          end
        end
        S_DEL_EV: begin
          if (!mem_q.is_free) in_use_r <= 1'b1;
          idx_r <= idx_r + 1'b1;
        end
        S_SUM_RD: begin
          if (scan_end) begin
            if (act_r == ACT_QUERY) begin
              res_r.status     <= ST_OK;
              res_r.bytes_free <= acc_r;
            end else begin
              res_r.status <= ST_NO_ROOM;
            end
          end
        end
        S_SUM_EV: begin
          if (mem_q.is_free) acc_r <= sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
          idx_r <= idx_r + 1'b1;
        end
        S_RND_WAIT: begin
          need_r <= rnd_need;
          idx_r  <= '0;
        end
        S_FIT_EV: begin
          ent_r <= mem_q;
          j_r   <= cnt_r;
          if (!fit_hit) begin
            idx_r <= idx_r + 1'b1;
          end else if (33'(mem_q.length) == need_r) begin
            res_r.status        <= ST_OK;
            res_r.block_address <= mem_q.start;
          end
        end
        S_UP_WR:  j_r <= j_r - 1'b1;
        S_SPLIT2: begin
          block_count_r[pool_r] <= cnt_r + 1'b1;
          res_r.status          <= ST_OK;
          res_r.block_address   <= ent_r.start;
        end
        S_FREE_EV: begin
          ent_r      <= mem_q;
          nxt_free_r <= 1'b0;
          prv_free_r <= 1'b0;
          if (!free_hit) idx_r <= idx_r + 1'b1;
        end
        S_NX_EV: begin
          next_r     <= mem_q;
          nxt_free_r <= mem_q.is_free;
        end
        S_PV_EV: begin
          prev_r     <= mem_q;
          prv_free_r <= mem_q.is_free;
        end
        S_MERGE: begin
          res_r.status <= ST_OK;
          if (prv_free_r) begin
            j_r  <= idx_r;
            sh_r <= nxt_free_r ? 2'd2 : 2'd1;
          end else begin
            j_r  <= idx_r + 1'b1;
            sh_r <= 2'd1;
          end
        end
        S_DN_RD: begin
          if (dn_end) block_count_r[pool_r] <= cnt_r - CW'(sh_r);
        end
        S_DN_WR:  j_r <= j_r + 1'b1;
        default: begin
        end
      endcase
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

>>> src/pool_first_fit_allocator_core.sv
// Top level of the pool first-fit allocator: table memory, rounding unit,
// sequencer and result register. Depends on pfa_pkg and all pfa_ modules.
//
// One request enters on the in_ channel and exactly one result leaves on
// the out_ channel, in order. in_tuser carries the action and in_tdata the
// pool id, size and address. out_tuser carries the status and out_tdata
// the new pool id, block address and free byte count.
// A create, or a request rejected when it is decoded, needs no table walk.
// A query or delete walks the pool's table once, a free walks to the block
// and then shifts the tail down when it merges with a free neighbour, and
// an allocate sums the pool while its size is rounded up to whole granules,
// walks to the first fit and shifts the tail up when it splits that block.
// Every table access goes through the single read port of the block memory.
// The next request is taken once the previous one has finished its work,
// even while its result still waits in the output register. When the
// receiver stalls, that result holds and the following one waits in the
// sequencer. Reset clears all pools; no memory clearing pass is needed.
`default_nettype none
module pool_first_fit_allocator_core #(
  parameter int NUM_POOLS       = 8,
  parameter int BLOCKS_PER_POOL = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // pool_id[2:0], req_size[34:3], address[66:35]
  input  wire logic [2:0]  in_tuser,   // action[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // new_pool[2:0], block_address[34:3], bytes_free[66:35]
  output logic [1:0]       out_tuser   // status[1:0]
);
  import pfa_pkg::*;

  localparam int DEPTH = NUM_POOLS * BLOCKS_PER_POOL;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_wdata;
  entry_t        mem_q;
  logic          rnd_start;
  logic          rnd_done;
  logic [32:0]   rnd_need;
  logic          res_valid;
  logic          res_ready;
  result_t       res;
  result_t       out_r;
  logic          out_valid_r;
  logic [31:0]   u_size_q;

  pfa_table #(.DEPTH(DEPTH), .AW(AW)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  pfa_rnd u_rnd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rnd_start),
    .size  (u_size_q),
    .done  (rnd_done),
    .need  (rnd_need)
  );

  pfa_ctrl #(
    .NUM_POOLS       (NUM_POOLS),
    .BLOCKS_PER_POOL (BLOCKS_PER_POOL),
    .AW              (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .action    (in_tuser),
    .pool_id   (in_tdata[2:0]),
    .req_size  (in_tdata[34:3]),
    .address   (in_tdata[66:35]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_q     (mem_q),
    .rnd_start (rnd_start),
    .rnd_done  (rnd_done),
    .rnd_need  (rnd_need)
  );

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      u_size_q <= in_tdata[34:3];
    end
  end

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
      out_r       <= res;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {5'd0, out_r.bytes_free, out_r.block_address, out_r.new_pool};

endmodule
`default_nettype wire
